[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// Clocked check that also runs during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

[rtl/core/frbg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package frbg_pkg;

    // Data width of numerator and results; the denominator is one bit narrower.
    localparam int WIDTH       = 32;
    localparam int DEN_W       = WIDTH - 1;
    localparam int CNT_W       = $clog2(WIDTH);
    localparam int IN_TDATA_W  = ((WIDTH + DEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request class decided at the front.
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,   // zero numerator
        K_DEN0 = 2'd1,   // nonzero numerator over zero denominator
        K_GCD  = 2'd2    // full reduction
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [WIDTH-1:0]   mag;
        logic [WIDTH-1:0]   den;
    } t_job;

endpackage

`default_nettype wire

[rtl/core/frbg_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module frbg_front (
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [frbg_pkg::IN_TDATA_W-1:0] i_s_tdata,  // numerator, denominator
    output logic                               o_push_valid,
    input  wire logic                          i_push_ready,
    output frbg_pkg::t_job                     o_job
);
    import frbg_pkg::*;

    logic [WIDTH-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic [WIDTH-1:0] mag;

    // Unpack the request
    assign num = i_s_tdata[WIDTH-1:0];
    assign den = i_s_tdata[WIDTH+DEN_W-1:WIDTH];

    // Magnitude and sign; the most negative value keeps its unsigned magnitude
    assign neg = num[WIDTH-1];
    assign mag = neg ? (WIDTH'(0) - num) : num;

    // Classify
    always_comb begin
        o_job.neg = neg;
        o_job.mag = mag;
        o_job.den = {1'b0, den};
        if (mag == '0) begin
            o_job.kind = K_ZERO;
        end else if (den == '0) begin
            o_job.kind = K_DEN0;
        end else begin
            o_job.kind = K_GCD;
        end
    end

    assign o_push_valid = i_s_tvalid;
    assign o_s_tready   = i_push_ready;

endmodule

`default_nettype wire

[rtl/core/frbg_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module frbg_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire frbg_pkg::t_job i_push_job,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output frbg_pkg::t_job      o_pop_job
);
    import frbg_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/frbg_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module frbg_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_valid,
    output logic                           o_job_ready,
    input  wire frbg_pkg::t_job            i_job,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [frbg_pkg::WIDTH-1:0]     o_num,
    output logic [frbg_pkg::WIDTH-1:0]     o_den
);
    import frbg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMON,
        S_ALIGN,
        S_REDUCE,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state           r_state,     n_state;
    logic [WIDTH-1:0] r_a,         n_a;       // gcd operand, ends as odd gcd
    logic [WIDTH-1:0] r_b,         n_b;
    logic [WIDTH-1:0] r_qn,        n_qn;      // numerator dividend -> quotient
    logic [WIDTH-1:0] r_qd,        n_qd;      // denominator dividend -> quotient
    logic [WIDTH-1:0] r_rn,        n_rn;      // partial remainders, below the divisor
    logic [WIDTH-1:0] r_rd,        n_rd;
    logic [CNT_W-1:0] r_cnt,       n_cnt;
    logic             r_neg,       n_neg;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_num,   n_out_num;
    logic [WIDTH-1:0] r_out_den,   n_out_den;

    logic [WIDTH:0]   trial_n;
    logic [WIDTH:0]   trial_d;
    logic [WIDTH:0]   divisor;
    logic             fit_n;
    logic             fit_d;

    // One restoring division step for both quotients, shared divisor
    assign divisor = {1'b0, r_a};
    assign trial_n = {r_rn[WIDTH-1:0], r_qn[WIDTH-1]};
    assign trial_d = {r_rd[WIDTH-1:0], r_qd[WIDTH-1]};
    assign fit_n   = (trial_n >= divisor);
    assign fit_d   = (trial_d >= divisor);

    assign o_job_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_num       = r_out_num;
    assign o_den       = r_out_den;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_qn        = r_qn;
        n_qd        = r_qd;
        n_rn        = r_rn;
        n_rd        = r_rd;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_valid = r_out_valid && !i_m_tready;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_neg = i_job.neg;
                    n_a   = i_job.mag;
                    n_b   = i_job.den;
                    n_qn  = i_job.mag;
                    n_qd  = i_job.den;
                    unique case (i_job.kind)
                        K_ZERO: begin
                            n_qn    = '0;
                            n_qd    = WIDTH'(1);
                            n_neg   = 1'b0;
                            n_state = S_DONE;
                        end
                        K_DEN0: begin
                            n_qn    = i_job.neg ? '1 : WIDTH'(1);
                            n_qd    = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_COMMON;
                        end
                    endcase
                end
            end
            // Strip the shared power of two from operands and dividends
            S_COMMON: begin
                if (r_a[0] || r_b[0]) begin
                    n_state = S_ALIGN;
                end else begin
                    n_a  = r_a  >> 1;
                    n_b  = r_b  >> 1;
                    n_qn = r_qn >> 1;
                    n_qd = r_qd >> 1;
                end
            end
            // Make a odd
            S_ALIGN: begin
                if (r_a[0]) begin
                    n_state = S_REDUCE;
                end else begin
                    n_a = r_a >> 1;
                end
            end
            // Odd-only subtraction, one shift or subtract per cycle
            S_REDUCE: begin
                if (r_b == '0) begin
                    n_rn    = '0;
                    n_rd    = '0;
                    n_cnt   = '0;
                    n_state = S_DIVIDE;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a > r_b) begin
                    n_a = r_b;
                    n_b = r_a - r_b;
                end else begin
                    n_b = r_b - r_a;
                end
            end
            // Exact division of both parts by the gcd, one bit per cycle
            S_DIVIDE: begin
                n_rn  = fit_n ? WIDTH'(trial_n - divisor) : trial_n[WIDTH-1:0];
                n_rd  = fit_d ? WIDTH'(trial_d - divisor) : trial_d[WIDTH-1:0];
                n_qn  = {r_qn[WIDTH-2:0], fit_n};
                n_qd  = {r_qd[WIDTH-2:0], fit_d};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_num   = r_qn;
                    n_out_den   = r_neg ? (WIDTH'(0) - r_qd) : r_qd;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_qn      <= n_qn;
        r_qd      <= n_qd;
        r_rn      <= n_rn;
        r_rd      <= n_rd;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fraction_reduce_binary_gcd.sv]
// Fraction reducer: brings numerator/denominator to lowest terms.
// Input stream s_axis: one request per handshake, numerator (signed) and
// denominator (unsigned). Output stream m_axis: one result per request, in order,
// reduced numerator and reduced denominator (both signed). A negative numerator
// gives a positive numerator over a negative denominator; 0/x gives 0/1 and
// x/0 gives +-1/0.
// The front classifies a request and writes it into a two-entry queue, so up to
// two requests are taken while the reducer is busy. The reducer runs one item
// at a time: it takes the item from the queue, then steps through the binary
// gcd (shared power-of-two strip, alignment, shift/subtract loop), then the
// bit-serial division of both parts, then loads the output register. Special
// cases skip the gcd and the division. Sustained throughput is set by the gcd
// loop and the divider. When the receiver stalls, the result holds in the
// output register while the next item is computed; it then waits in the
// reducer, and the queue fills.
// Synchronous active-low reset empties the queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module fraction_reduce_binary_gcd (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [31:0] numerator, [62:32] denominator, [63] unused
    input  wire logic [frbg_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [31:0] reduced_numerator, [63:32] reduced_denominator
    output logic [frbg_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import frbg_pkg::*;

    logic             push_valid;
    logic             push_ready;
    t_job             push_job;
    logic             pop_valid;
    logic             pop_ready;
    t_job             pop_job;
    logic [WIDTH-1:0] out_num;
    logic [WIDTH-1:0] out_den;

    frbg_front u_front (
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_job        (push_job)
    );

    frbg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    frbg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_num       (out_num),
        .o_den       (out_den)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({out_den, out_num});

endmodule

`default_nettype wire

[rtl/core/frbg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frbg_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [frbg_pkg::OUT_TDATA_W-1:0] i_out_data
);
    import frbg_pkg::*;

    logic [WIDTH-1:0] res_num;
    logic [WIDTH-1:0] res_den;

    assign res_num = i_out_data[WIDTH-1:0];
    assign res_den = i_out_data[2*WIDTH-1:WIDTH];

    // A stalled result stays offered
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // Reset drops any pending result
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // A zero numerator is always reported over one
    `ASSERT_CLK(a_zero_num, i_clk, i_rst_n, i_out_valid && res_num == '0 |-> res_den == WIDTH'(1))

    // A zero denominator only comes with a unit numerator
    `ASSERT_CLK(a_zero_den, i_clk, i_rst_n, i_out_valid && res_den == '0 |-> (res_num == WIDTH'(1) || res_num == '1))

endmodule

bind fraction_reduce_binary_gcd frbg_checker u_frbg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata)
);

`default_nettype wire
